// ----- src/wtf_pkg.sv -----
`default_nettype none

package wtf_pkg;

  localparam logic [7:0] DASH = 8'h2D;
  localparam logic [7:0] UPPER_FIRST = 8'h41;
  localparam logic [7:0] UPPER_LAST = 8'h5A;
  localparam logic [7:0] LOWER_FIRST = 8'h61;
  localparam logic [7:0] LOWER_LAST = 8'h7A;
  localparam logic [7:0] DIGIT_FIRST = 8'h30;
  localparam logic [7:0] DIGIT_LAST = 8'h39;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        word_end;
    logic [15:0] word_count;
    logic        truncated;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SEND
  } state_t;

  typedef struct packed {
    logic take;
    logic fetch;
    logic advance;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic emit_start;
    logic last;
  } status_t;

endpackage

`default_nettype wire

// ----- src/wtf_ctrl.sv -----
`default_nettype none

module wtf_ctrl
  import wtf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && status.emit_start) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        if (out_ready) begin
          state_next = status.last ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
      end
      S_SEND: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready && !status.last;
        cmd.finish  = out_ready && status.last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/wtf_datapath.sv -----
`default_nettype none

module wtf_datapath
  import wtf_pkg::*;
#(
  parameter int MAX_WORD = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire in_t  in_item,
  input  wire cmd_t cmd,
  output status_t   status,
  output out_t      out_item
);

  localparam int AW = $clog2(MAX_WORD);
  localparam int LW = $clog2(MAX_WORD + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_WORD);

  logic [7:0]    word_buffer [MAX_WORD];
  logic [7:0]    rd_data;
  logic [LW-1:0] word_length;
  logic          has_letter;
  logic          overflowed;
  logic [15:0]   words_seen;
  logic [AW-1:0] idx;

  logic          is_upper;
  logic          is_letter;
  logic          is_word;
  logic          full;
  logic          flush;
  logic [7:0]    lc_byte;
  logic [LW-1:0] length_next;
  logic          has_letter_next;
  logic          overflowed_next;

  always_comb begin
    is_upper  = (in_item.in_byte >= UPPER_FIRST) && (in_item.in_byte <= UPPER_LAST);
    is_letter = is_upper ||
                ((in_item.in_byte >= LOWER_FIRST) && (in_item.in_byte <= LOWER_LAST));
    is_word   = is_letter || (in_item.in_byte == DASH) ||
                ((in_item.in_byte >= DIGIT_FIRST) && (in_item.in_byte <= DIGIT_LAST));
    lc_byte   = is_upper ? (in_item.in_byte + CASE_OFFSET) : in_item.in_byte;
    full      = (word_length == LEN_MAX);
    length_next     = (is_word && !full) ? (word_length + LW'(1)) : word_length;
    has_letter_next = has_letter || is_letter;
    overflowed_next = overflowed || (is_word && full);
    flush           = !is_word || in_item.end_of_text;
    status.emit_start = flush && has_letter_next;
    status.last       = ((LW'(idx) + LW'(1)) == word_length);
  end

  always_ff @(posedge clk) begin
    if (cmd.take && is_word && !full) begin
      word_buffer[word_length[AW-1:0]] <= lc_byte;
    end
    if (cmd.fetch) begin
      rd_data <= word_buffer[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length <= '0;
      has_letter  <= 1'b0;
      overflowed  <= 1'b0;
      words_seen  <= '0;
      idx         <= '0;
    end else begin
      if (cmd.take) begin
        if (flush && !has_letter_next) begin
          word_length <= '0;
          has_letter  <= 1'b0;
          overflowed  <= 1'b0;
        end else begin
          word_length <= length_next;
          has_letter  <= has_letter_next;
          overflowed  <= overflowed_next;
        end
        if (status.emit_start) begin
          idx <= '0;
          if (words_seen != COUNT_MAX) begin
            words_seen <= words_seen + 16'd1;
          end
        end
      end
      if (cmd.advance) begin
        idx <= idx + AW'(1);
      end
      if (cmd.finish) begin
        word_length <= '0;
        has_letter  <= 1'b0;
        overflowed  <= 1'b0;
      end
    end
  end

  always_comb begin
    out_item.out_char   = rd_data;
    out_item.word_end   = status.last;
    out_item.word_count = words_seen;
    out_item.truncated  = overflowed;
  end

endmodule

`default_nettype wire

// ----- src/word_tokenizer_filter.sv -----
// Word tokenizer and filter.
// Text arrives one byte per transfer on the input channel (in_valid, in_ready,
// in_item). Letters, digits and dash are collected, lowercased, in a word
// buffer of MAX_WORD bytes. Any other byte, or a byte marked end_of_text, ends
// the word; a word holding at least one letter is then sent on the output
// channel (out_valid, out_ready, out_item) one byte per transfer, with the
// final byte marked and a saturating count of words sent so far.
// A byte that does not end a word, or ends one without a letter, leaves the
// controller idle. A byte that ends a real word moves it to a fetch state, in
// which a word byte is read from the word buffer, and then to a send state, in
// which that byte is presented; this repeats for each word byte. No input is
// taken while a word is being sent. When the receiver stalls, the current byte
// is held unchanged until it is taken. Reset returns the controller to idle
// and clears the word state and the count; the buffer needs no clearing.
`default_nettype none

module word_tokenizer_filter
  import wtf_pkg::*;
#(
  parameter int MAX_WORD = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_item,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_item
);

  cmd_t    cmd;
  status_t status;

  wtf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  wtf_datapath #(
    .MAX_WORD (MAX_WORD)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
